// ----- rtl/core/windowed_event_rate_estimator_top_defines.svh -----
// Assertion macros shared by the event rate estimator RTL.
`ifndef WINDOWED_EVENT_RATE_ESTIMATOR_TOP_DEFINES_SVH
`define WINDOWED_EVENT_RATE_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define WERS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wers: assertion failed");

// Next-cycle implication, checked on clk_i outside reset.
`define WERS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wers: assertion failed");

`endif

// ----- rtl/core/wers_pkg.sv -----
// Shared types, constants and the Blackman weight table of the event rate estimator.
package wers_pkg;

  localparam int TAPS      = 32;
  localparam int RING_LEN  = TAPS + 1;
  localparam int COUNT_W   = 16;
  localparam int WEIGHT_W  = 16;
  localparam int BIN_W     = 32;
  localparam int BPS_W     = 24;
  localparam int RATE_W    = 40;
  localparam int ACC_W     = 40;
  localparam int PROD_W    = WEIGHT_W + COUNT_W;
  localparam int TAP_CNT_W = $clog2(TAPS + 1);
  localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SHIFT_W   = $clog2(RING_LEN);

  localparam logic [BPS_W-1:0]   BPS_RESET = BPS_W'(256);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

  localparam longint unsigned PI_Q28  = 64'd843314857;
  localparam longint unsigned ONE_Q28 = 64'd268435456;

  // Taylor divisors (2n+1)(2n+2) of the cosine series, n = 0..19.
  localparam longint unsigned TAYLOR_DIV [20] = '{
    64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,  64'd182,  64'd240,  64'd306,  64'd380,
    64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992, 64'd1122, 64'd1260, 64'd1406, 64'd1560
  };

  typedef logic [TAPS-1:0][WEIGHT_W-1:0] weight_rom_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_CLEAR,
    CELL_INC
  } cell_op_e;

  typedef struct packed {
    logic                 clr;
    logic                 en;
    logic                 scale;
    logic [TAP_IDX_W-1:0] idx;
  } mac_ctrl_t;

  // cos(2*pi*k/RING_LEN) in signed Q28, Taylor series to twenty terms.
  function automatic longint cos_q28(input int unsigned k_in);
    longint unsigned k;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned mag;
    longint          sum;
    k = longint'(k_in) % RING_LEN;
    if (2 * k > RING_LEN) begin
      k = RING_LEN - k;
    end
    theta = (2 * PI_Q28 * k) / RING_LEN;
    t2    = (theta * theta) >> 28;
    mag   = ONE_Q28;
    sum   = longint'(ONE_Q28);
    for (int n = 0; n < 20; n++) begin
      mag  = (mag * t2) >> 28;
      mag  = mag / TAYLOR_DIV[n];
      if ((n % 2) != 0) begin
        sum = sum + longint'(mag);
      end else begin
        sum = sum - longint'(mag);
      end
    end
    return sum;
  endfunction

  // Unnormalized Blackman value of tap p, clamped at zero.
  function automatic longint blackman_raw(input int p);
    longint x;
    x = 42 * longint'(ONE_Q28) - 50 * cos_q28(p + 1) + 8 * cos_q28(2 * (p + 1));
    if (x < 0) begin
      x = 0;
    end
    return x;
  endfunction

  function automatic longint unsigned weight_sum();
    longint unsigned s;
    s = 0;
    for (int p = 0; p < TAPS; p++) begin
      s = s + longint'(blackman_raw(p));
    end
    return s;
  endfunction

  localparam longint unsigned WEIGHT_SUM  = weight_sum();
  localparam longint unsigned WEIGHT_HALF = WEIGHT_SUM / 2;

  // Normalized Blackman weights, Q0.16, evaluated at elaboration.
  function automatic weight_rom_t build_weights();
    longint unsigned w;
    weight_rom_t     rom;
    for (int p = 0; p < TAPS; p++) begin
      if (WEIGHT_SUM == 0) begin
        rom[p] = '0;
      end else begin
        w      = ($unsigned(blackman_raw(p)) * 64'd65536 + WEIGHT_HALF) / WEIGHT_SUM;
        rom[p] = (w > 64'd65535) ? '1 : w[WEIGHT_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weights();

endpackage

// ----- rtl/core/wers_if.sv -----
// Handshake channels of the event rate estimator: events in, rates out, configuration.
interface wers_bin_if;
  logic                      valid;
  logic                      ready;
  logic [wers_pkg::BIN_W-1:0] bin_number;
  modport source (output valid, output bin_number, input ready);
  modport sink   (input valid, input bin_number, output ready);
endinterface

interface wers_rate_if;
  logic                       valid;
  logic                       ready;
  logic [wers_pkg::RATE_W-1:0] rate_estimate;
  modport source (output valid, output rate_estimate, input ready);
  modport sink   (input valid, input rate_estimate, output ready);
endinterface

interface wers_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wers_pkg::BPS_W-1:0] bins_per_second;
  modport source (output valid, output bins_per_second, input ready);
  modport sink   (input valid, input bins_per_second, output ready);
endinterface

// ----- rtl/core/wers_cell.sv -----
// One bin count cell of the ring: hold, take the neighbor's count, clear or increment.
module wers_cell import wers_pkg::*; (
  input  logic               clk_i,
  input  cell_op_e           op_i,
  input  logic [COUNT_W-1:0] shift_i,
  output logic [COUNT_W-1:0] count_o
);

  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_d;

  always_comb begin
    count_d = count_q;
    unique case (op_i)
      CELL_HOLD:  count_d = count_q;
      CELL_SHIFT: count_d = shift_i;
      CELL_CLEAR: count_d = '0;
      CELL_INC:   count_d = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
      default:    count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign count_o = count_q;

endmodule

// ----- rtl/core/wers_mac.sv -----
// Weighted sum of the counts leaving the chain, then scaling by the bin rate.
module wers_mac import wers_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic [COUNT_W-1:0] count_i,
  input  logic [BPS_W-1:0]   bps_i,
  output logic [RATE_W-1:0]  rate_o
);

  logic [PROD_W-1:0]          prod_q;
  logic                       prod_vld_q;
  logic [ACC_W-1:0]           acc_q;
  logic [ACC_W-16+BPS_W-1:0]  hi_q;
  logic [16+BPS_W-1:0]        lo_q;
  logic [16+BPS_W:0]          lo_rnd;
  logic [ACC_W-16+BPS_W:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= WEIGHT_ROM[ctrl_i.idx] * count_i;
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.scale) begin
      hi_q <= acc_q[ACC_W-1:16] * bps_i;
      lo_q <= acc_q[15:0] * bps_i;
    end
  end

  // Round the low part half up, then saturate the sum.
  always_comb begin
    lo_rnd = {1'b0, lo_q} + (16+BPS_W+1)'(17'h08000);
    sum    = {1'b0, hi_q} + (ACC_W-16+BPS_W+1)'(lo_rnd[16+BPS_W:16]);
    rate_o = (sum > (ACC_W-16+BPS_W+1)'(RATE_MAX)) ? RATE_MAX : sum[RATE_W-1:0];
  end

endmodule

// ----- rtl/core/windowed_event_rate_estimator_top.sv -----
// Event rate estimator: a chain of TAPS+1 bin count cells, shifted on bin advance and
// rotated once past a shared multiplier for each event. Each event's result is valid
// after these steps, in order: one shift for each bin that it advances the window (none
// when the bin repeats or the window is cleared, at most TAPS), the increment, a full
// rotation of the ring through the single multiply-accumulate, the rate scaling and the
// load of the result register. The next request is taken after that load; the load
// waits while an earlier result is still held in the register. A finished result
// waits in its register while the next request is taken. No clearing pass is needed
// after reset: the first event clears the ring.
`include "windowed_event_rate_estimator_top_defines.svh"

module windowed_event_rate_estimator_top import wers_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  wers_bin_if.sink   bin_i,
  wers_cfg_if.sink   cfg_i,
  wers_rate_if.source rate_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_INC,
    S_MAC,
    S_SCALE,
    S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [BIN_W-1:0]     newest_q, newest_d;
  logic                 started_q, started_d;
  logic [SHIFT_W-1:0]   shift_q, shift_d;
  logic [TAP_CNT_W-1:0] tap_q, tap_d;
  logic [BPS_W-1:0]     bps_q, bps_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic                 rate_valid_q, rate_valid_d;

  logic [BIN_W-1:0]     bin_gap;
  logic                 bin_acc;
  cell_op_e             cell_op [RING_LEN];
  logic [COUNT_W-1:0]   count [RING_LEN];
  logic [COUNT_W-1:0]   head_in;
  mac_ctrl_t            mac_ctrl;
  logic [RATE_W-1:0]    mac_rate;

  assign bin_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready          = 1'b1;
  assign rate_o.valid         = rate_valid_q;
  assign rate_o.rate_estimate = rate_q;

  assign bin_acc = bin_i.valid && bin_i.ready;
  assign bin_gap = bin_i.bin_number - newest_q;

  always_comb begin
    state_d      = state_q;
    newest_d     = newest_q;
    started_d    = started_q;
    shift_d      = shift_q;
    tap_d        = tap_q;
    bps_d        = bps_q;
    rate_d       = rate_q;
    rate_valid_d = rate_valid_q;
    head_in      = '0;
    mac_ctrl     = '0;
    for (int k = 0; k < RING_LEN; k++) begin
      cell_op[k] = CELL_HOLD;
    end

    if (cfg_i.valid) begin
      bps_d = cfg_i.bins_per_second;
    end
    if (rate_valid_q && rate_o.ready) begin
      rate_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (bin_acc) begin
          newest_d  = bin_i.bin_number;
          started_d = 1'b1;
          if (!started_q || bin_gap >= BIN_W'(RING_LEN)) begin
            for (int k = 0; k < RING_LEN; k++) begin
              cell_op[k] = CELL_CLEAR;
            end
            state_d = S_INC;
          end else if (bin_gap == '0) begin
            state_d = S_INC;
          end else begin
            shift_d = bin_gap[SHIFT_W-1:0];
            state_d = S_ADV;
          end
        end
      end
      S_ADV: begin
        // Advance one bin, zero entering at the newest end.
        for (int k = 0; k < RING_LEN; k++) begin
          cell_op[k] = CELL_SHIFT;
        end
        shift_d = shift_q - SHIFT_W'(1);
        if (shift_q == SHIFT_W'(1)) begin
          state_d = S_INC;
        end
      end
      S_INC: begin
        cell_op[0]   = CELL_INC;
        mac_ctrl.clr = 1'b1;
        tap_d        = '0;
        state_d      = S_MAC;
      end
      S_MAC: begin
        // Rotate the whole ring; the oldest cell feeds the multiplier.
        head_in = count[RING_LEN-1];
        for (int k = 0; k < RING_LEN; k++) begin
          cell_op[k] = CELL_SHIFT;
        end
        mac_ctrl.en  = (tap_q < TAP_CNT_W'(TAPS));
        mac_ctrl.idx = tap_q[TAP_IDX_W-1:0];
        tap_d        = tap_q + TAP_CNT_W'(1);
        if (tap_q == TAP_CNT_W'(TAPS)) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        mac_ctrl.scale = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (!rate_valid_q || rate_o.ready) begin
          rate_d       = mac_rate;
          rate_valid_d = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      newest_q     <= '0;
      started_q    <= 1'b0;
      shift_q      <= '0;
      tap_q        <= '0;
      bps_q        <= BPS_RESET;
      rate_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      newest_q     <= newest_d;
      started_q    <= started_d;
      shift_q      <= shift_d;
      tap_q        <= tap_d;
      bps_q        <= bps_d;
      rate_valid_q <= rate_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
  end

  for (genvar g = 0; g < RING_LEN; g++) begin : g_cell
    wers_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .shift_i ((g == 0) ? head_in : count[(g == 0) ? 0 : g - 1]),
      .count_o (count[g])
    );
  end

  wers_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .count_i (count[RING_LEN-1]),
    .bps_i   (bps_q),
    .rate_o  (mac_rate)
  );

  `WERS_ASSERT_NXT(a_accept_leaves_idle, bin_acc, state_q != S_IDLE)
  `WERS_ASSERT_IMP(a_adv_count_nonzero, state_q == S_ADV, shift_q != '0)
  `WERS_ASSERT_IMP(a_tap_in_range, state_q == S_MAC, tap_q <= TAP_CNT_W'(TAPS))
  `WERS_ASSERT_NXT(a_fin_holds, state_q == S_FIN && rate_valid_q && !rate_o.ready, state_q == S_FIN)

endmodule
